@@ hdl/thrt_pkg.sv @@
package thrt_pkg;

   localparam int NODE_COUNT_DEFAULT = 32;
   localparam int TABLE_SIZE = 32;
   localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);
   localparam int ADDR_W = 6;
   localparam int MAP_W = 32;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_BEACON = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] METRIC_DIRECT = 2'd1;
   localparam logic [1:0] METRIC_TWO_HOP = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] sender_id;
      logic [MAP_W-1:0]  sender_neighbours;
      logic [ADDR_W-1:0] destination;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] next_node;
      logic              use_broadcast;
      logic              is_neighbour;
      logic [1:0]        route_metric;
      logic              bad_address;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] next_node;
      logic [1:0]        metric;
   } entry_type;

   typedef struct packed {
      logic                   clear;
      logic                   wr_en;
      logic [TABLE_IDX_W-1:0] wr_idx;
      entry_type              wr_entry;
      logic                   rd_en;
      logic [TABLE_IDX_W-1:0] rd_idx;
   } tbl_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LOOKUP
   } state_type;

endpackage

@@ hdl/thrt_table.sv @@
module thrt_table (
   input  logic                  clock,
   input  logic                  reset,
   input  thrt_pkg::tbl_cmd_type cmd,
   output thrt_pkg::entry_type   rd_entry,
   output logic                  rd_hit
);

   thrt_pkg::entry_type                   mem_ff [thrt_pkg::TABLE_SIZE];
   logic [thrt_pkg::TABLE_SIZE-1:0]       valid_ff;
   logic [thrt_pkg::TABLE_SIZE-1:0]       valid_in;
   thrt_pkg::entry_type                   rd_data_ff;
   logic                                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[cmd.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_idx] <= cmd.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff  <= mem_ff[cmd.rd_idx];
         rd_valid_ff <= valid_ff[cmd.rd_idx];
      end
   end

   // an entry never written since the last clear reads as empty
   assign rd_hit   = rd_valid_ff;
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hdl/two_hop_route_table.sv @@
// channel | ports                              | direction
// req     | req_valid, req_ready, req_data     | in: clear, beacon or lookup item
// rsp     | rsp_valid, rsp_ready, rsp_data     | out: one result per item
// csr     | csr_write_enable, csr_write_data   | in: own_address, no wait
//
// clear, kind 3 and a beacon with a bad sender reply straight from idle; a lookup first
// does one synchronous read of the route table; a valid beacon then sweeps the first
// min(NODE_COUNT, 32) table entries, with one table write slot per node in the sweep.
// reset empties the route table through per-entry valid bits and sets own_address to 1.
// the result register holds while rsp_ready is low; a lookup waits in place for it.
module two_hop_route_table #(
   parameter int NODE_COUNT = thrt_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  thrt_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output thrt_pkg::rsp_type           rsp_data,
   input  logic                        csr_write_enable,
   input  logic [thrt_pkg::ADDR_W-1:0] csr_write_data
);

   localparam int IdLimit = (NODE_COUNT < thrt_pkg::TABLE_SIZE) ?
                            NODE_COUNT : thrt_pkg::TABLE_SIZE;
   localparam logic [thrt_pkg::MAP_W-1:0] LimitMask =
      thrt_pkg::MAP_W'((64'(1) << IdLimit) - 64'(1));
   localparam logic [thrt_pkg::ADDR_W:0] IdLimitW = (thrt_pkg::ADDR_W + 1)'(IdLimit);
   localparam logic [thrt_pkg::TABLE_IDX_W-1:0] LastIdx =
      thrt_pkg::TABLE_IDX_W'(IdLimit - 1);

   thrt_pkg::state_type                  state_ff, state_in;
   logic [thrt_pkg::ADDR_W-1:0]          own_ff, own_in;
   logic [thrt_pkg::MAP_W-1:0]           map_ff, map_in;
   logic [thrt_pkg::ADDR_W-1:0]          lowest_ff, lowest_in;
   logic [thrt_pkg::ADDR_W-1:0]          sender_ff, sender_in;
   logic [thrt_pkg::MAP_W-1:0]           wmask_ff, wmask_in;
   logic [thrt_pkg::TABLE_IDX_W-1:0]     sweep_ff, sweep_in;
   logic [thrt_pkg::TABLE_IDX_W-1:0]     didx_ff, didx_in;
   logic                                 dbad_ff, dbad_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   thrt_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   thrt_pkg::tbl_cmd_type                cmd;
   thrt_pkg::entry_type                  rd_entry;
   logic                                 rd_hit;

   logic                                 out_free;
   logic                                 accept;
   logic                                 own_valid;
   logic [thrt_pkg::MAP_W-1:0]           own_bit;
   logic                                 sender_valid;
   logic [thrt_pkg::TABLE_IDX_W-1:0]     sender_idx;
   logic [thrt_pkg::MAP_W-1:0]           sender_bit;
   logic                                 sender_new;
   logic [thrt_pkg::MAP_W-1:0]           map_upd;
   logic                                 dest_valid;
   logic [thrt_pkg::TABLE_IDX_W-1:0]     sweep_sender_idx;

   thrt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_entry (rd_entry),
      .rd_hit   (rd_hit)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == thrt_pkg::ST_IDLE) &&
                      ((req_data.kind == thrt_pkg::KIND_LOOKUP) || out_free);
   assign accept    = req_valid && req_ready;

   assign own_valid  = (own_ff != '0) && ({1'b0, own_ff} <= IdLimitW);
   assign own_bit    = thrt_pkg::MAP_W'(1) << thrt_pkg::TABLE_IDX_W'(own_ff - 1'b1);

   assign sender_valid = (req_data.sender_id != '0) && ({1'b0, req_data.sender_id} <= IdLimitW);
   assign sender_idx   = thrt_pkg::TABLE_IDX_W'(req_data.sender_id - 1'b1);
   assign sender_bit   = thrt_pkg::MAP_W'(1) << sender_idx;
   assign sender_new   = !map_ff[sender_idx];
   assign map_upd      = map_ff | sender_bit;

   assign dest_valid = (req_data.destination != '0) &&
                       ({1'b0, req_data.destination} <= IdLimitW);

   assign sweep_sender_idx = thrt_pkg::TABLE_IDX_W'(sender_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      own_in       = csr_write_enable ? csr_write_data : own_ff;
      map_in       = map_ff;
      lowest_in    = lowest_ff;
      sender_in    = sender_ff;
      wmask_in     = wmask_ff;
      sweep_in     = sweep_ff;
      didx_in      = didx_ff;
      dbad_in      = dbad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;

      unique case (state_ff)
         thrt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  thrt_pkg::KIND_CLEAR: begin
                     cmd.clear    = 1'b1;
                     map_in       = own_valid ? own_bit : '0;
                     lowest_in    = own_valid ? own_ff : '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  thrt_pkg::KIND_BEACON: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     if (sender_valid) begin
                        map_in = map_upd;
                        // the lowest neighbour can only drop when a new sender joins
                        if (sender_new && ((lowest_ff == '0) ||
                                           (req_data.sender_id < lowest_ff))) begin
                           lowest_in = req_data.sender_id;
                        end
                        wmask_in  = (req_data.sender_neighbours & ~map_upd & LimitMask) |
                                    (sender_new ? sender_bit : '0);
                        sender_in = req_data.sender_id;
                        sweep_in  = '0;
                        state_in  = thrt_pkg::ST_SWEEP;
                     end
                  end
                  thrt_pkg::KIND_LOOKUP: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_idx = thrt_pkg::TABLE_IDX_W'(req_data.destination - 1'b1);
                     didx_in    = thrt_pkg::TABLE_IDX_W'(req_data.destination - 1'b1);
                     dbad_in    = !dest_valid;
                     state_in   = thrt_pkg::ST_LOOKUP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         thrt_pkg::ST_SWEEP: begin
            // sender entry (if new) and two-hop entries share next hop = sender
            cmd.wr_en              = wmask_ff[sweep_ff];
            cmd.wr_idx             = sweep_ff;
            cmd.wr_entry.next_node = sender_ff;
            cmd.wr_entry.metric    = (sweep_ff == sweep_sender_idx) ?
                                     thrt_pkg::METRIC_DIRECT : thrt_pkg::METRIC_TWO_HOP;
            sweep_in               = sweep_ff + 1'b1;
            if (sweep_ff == LastIdx) begin
               state_in = thrt_pkg::ST_IDLE;
            end
         end
         thrt_pkg::ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (dbad_ff) begin
                  rsp_data_in.bad_address = 1'b1;
               end else begin
                  rsp_data_in.is_neighbour  = map_ff[didx_ff];
                  rsp_data_in.route_metric  = rd_entry.metric;
                  rsp_data_in.next_node     = rd_hit ? rd_entry.next_node : lowest_ff;
                  rsp_data_in.use_broadcast = !rd_hit && (lowest_ff == '0);
               end
               state_in = thrt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thrt_pkg::ST_IDLE;
         own_ff       <= thrt_pkg::ADDR_W'(1);
         map_ff       <= '0;
         lowest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_ff       <= own_in;
         map_ff       <= map_in;
         lowest_ff    <= lowest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sender_ff   <= sender_in;
      wmask_ff    <= wmask_in;
      sweep_ff    <= sweep_in;
      didx_ff     <= didx_in;
      dbad_ff     <= dbad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
